### rtl/core/bmm_pkg.sv
// Shared types and constants for the binary mask 3x3 morphology block
`timescale 1ns / 1ps
`default_nettype none

package bmm_pkg;

    localparam int CFG_W          = 13;
    localparam int COORD_W        = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    typedef logic [CFG_W-1:0]     cfg_data_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [COORD_W-1:0]   coord_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_OP_MODE      = 2'd2,
        REG_BORDER_VALUE = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_GROW   = 1'b0,
        OP_SHRINK = 1'b1
    } op_mode_t;

    localparam cfg_data_t FRAME_WIDTH_RST  = 13'd4096;
    localparam cfg_data_t FRAME_HEIGHT_RST = 13'd4096;

    // one line-store entry: the two rows above the current input row
    typedef struct packed {
        logic middle;
        logic upper;
    } ls_word_t;

endpackage

`default_nettype wire

### rtl/core/bmm_if.sv
// Channel interfaces: pixel input, result output, configuration writes
`timescale 1ns / 1ps
`default_nettype none

interface bmm_pix_if;
    logic valid;
    logic ready;
    logic pixel_bit;
    logic flush;

    modport source (output valid, output pixel_bit, output flush, input ready);
    modport sink   (input valid, input pixel_bit, input flush, output ready);
endinterface

interface bmm_res_if;
    logic           valid;
    logic           ready;
    logic           result_bit;
    bmm_pkg::coord_t out_col;
    bmm_pkg::coord_t out_row;
    logic           last_of_frame;

    modport source (output valid, output result_bit, output out_col, output out_row,
                    output last_of_frame, input ready);
    modport sink   (input valid, input result_bit, input out_col, input out_row,
                    input last_of_frame, output ready);
endinterface

interface bmm_cfg_if;
    logic              valid;
    logic              ready;
    bmm_pkg::cfg_idx_t  index;
    bmm_pkg::cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/bmm_line_store.sv
// Two-row line store: one write port, one registered read port with write bypass
`timescale 1ns / 1ps
`default_nettype none

module bmm_line_store #(
    parameter int  DEPTH = bmm_pkg::MAX_WIDTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output bmm_pkg::ls_word_t rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  bmm_pkg::ls_word_t wr_data
);
    import bmm_pkg::*;

    ls_word_t mem [DEPTH];
    ls_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // same-column read and write on one edge (narrow frames): take new data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/binary_mask_3x3_morphology_unit.sv
// Top level: 3x3 binary grow/shrink over a raster mask stream
//
//   channel   role    fields
//   pixels    sink    pixel_bit, flush
//   results   source  result_bit, out_col, out_row, last_of_frame
//   cfg       sink    index, data (always ready)
//
// One item per cycle sustained while results are accepted. Each item passes an
// input stage (counters, line-store read) and a compute stage (window, 3x3
// reduce) into the output register, which drives the result port.
// Reset clears counters, window and config; the line store is not cleared.
// Stalls: results.ready low holds only items that carry a result.
`timescale 1ns / 1ps
`default_nettype none

module binary_mask_3x3_morphology_unit #(
    parameter int MAX_WIDTH  = bmm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmm_pkg::MAX_HEIGHT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bmm_pix_if.sink   pixels,
    bmm_res_if.source results,
    bmm_cfg_if.sink   cfg
);
    import bmm_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int EW  = $clog2(MAX_WIDTH + 1);
    localparam int EH  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int CW  = (EW > CFG_W) ? EW : CFG_W;
    localparam int CH  = (EH > CFG_W) ? EH : CFG_W;
    localparam int XW0 = (RW > EW) ? RW : EW;
    localparam int XW  = (XW0 > COORD_W) ? XW0 : COORD_W;

    // configuration
    cfg_data_t frame_width_reg;
    cfg_data_t frame_height_reg;
    op_mode_t  op_mode_reg;
    logic      border_reg;
    logic      size_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            op_mode_reg      <= OP_GROW;
            border_reg       <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                REG_OP_MODE:      op_mode_reg      <= op_mode_t'(cfg.data[0]);
                REG_BORDER_VALUE: border_reg       <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    assign cfg.ready  = 1'b1;
    assign size_write = cfg.valid && ((cfg_reg_t'(cfg.index) == REG_FRAME_WIDTH) ||
                                      (cfg_reg_t'(cfg.index) == REG_FRAME_HEIGHT));

    // effective frame size
    logic [CW-1:0] fw_ext;
    logic [CH-1:0] fh_ext;
    logic [EW-1:0] ew;
    logic [EH-1:0] eh;
    logic [RW-1:0] eh_r;
    logic [RW-1:0] eh_p1;

    assign fw_ext = CW'(frame_width_reg);
    assign fh_ext = CH'(frame_height_reg);
    assign ew = (fw_ext == '0) ? EW'(1) :
                (fw_ext > CW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(fw_ext);
    assign eh = (fh_ext == '0) ? EH'(1) :
                (fh_ext > CH'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : EH'(fh_ext);
    assign eh_r  = RW'(eh);
    assign eh_p1 = eh_r + RW'(1);

    // input stage
    logic [AW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic          in_fire;
    logic [AW-1:0] s0_col;
    logic          s0_col_zero, s0_col_ge2, s0_row_ge1, s0_row_ge2;
    logic          s0_pix, s0_emit, s0_last;
    logic [XW-1:0] s0_er_full, s0_ec_full;
    logic [EW-1:0] col_inc;
    logic          col_wrap;
    logic [RW:0]   row_inc;

    assign in_fire = pixels.valid && pixels.ready;

    always_comb
    begin
        s0_col      = (EW'(in_col_reg) < ew) ? in_col_reg : '0;
        s0_col_zero = (s0_col == '0);
        s0_col_ge2  = (s0_col >= AW'(2));
        s0_row_ge1  = (in_row_reg != '0);
        s0_row_ge2  = (in_row_reg >= RW'(2));
        s0_pix      = (pixels.flush || (in_row_reg >= eh_r)) ? border_reg : pixels.pixel_bit;
        s0_emit     = s0_col_zero ? s0_row_ge2 : (s0_row_ge1 && (in_row_reg <= eh_r));
        s0_last     = s0_col_zero && s0_row_ge2 && (in_row_reg == eh_p1);
        s0_er_full  = XW'(in_row_reg) - (s0_col_zero ? XW'(2) : XW'(1));
        s0_ec_full  = s0_col_zero ? (XW'(ew) - XW'(1)) : (XW'(s0_col) - XW'(1));

        col_inc  = EW'(s0_col) + EW'(1);
        col_wrap = (col_inc >= ew);
        row_inc  = {1'b0, in_row_reg} + (RW+1)'(col_wrap);

        if (s0_last)
        begin
            in_col_next = '0;
            in_row_next = '0;
        end
        else
        begin
            in_col_next = col_wrap ? '0 : col_inc[AW-1:0];
            in_row_next = (row_inc > {1'b0, eh_p1}) ? eh_p1 : row_inc[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else if (size_write)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else if (in_fire)
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
        end
    end

    // compute stage
    logic          s1_valid_reg;
    logic [AW-1:0] s1_col_reg;
    logic          s1_pix_reg, s1_col_zero_reg, s1_col_ge2_reg;
    logic          s1_row_ge1_reg, s1_row_ge2_reg, s1_emit_reg, s1_last_reg;
    coord_t        s1_er_reg, s1_ec_reg;
    logic          s1_adv;
    ls_word_t      rd_word, wr_word;
    logic [8:0]    window_reg, window_next;
    logic [2:0]    newcol, bcol, left, centre, right;
    logic [8:0]    shifted, nine;
    logic          top_bit, mid_bit, res_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixels.ready)
        begin
            s1_valid_reg <= pixels.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_col_reg      <= s0_col;
            s1_pix_reg      <= s0_pix;
            s1_col_zero_reg <= s0_col_zero;
            s1_col_ge2_reg  <= s0_col_ge2;
            s1_row_ge1_reg  <= s0_row_ge1;
            s1_row_ge2_reg  <= s0_row_ge2;
            s1_emit_reg     <= s0_emit;
            s1_last_reg     <= s0_last;
            s1_er_reg       <= s0_er_full[COORD_W-1:0];
            s1_ec_reg       <= s0_ec_full[COORD_W-1:0];
        end
    end

    assign s1_adv       = s1_valid_reg && (!s1_emit_reg || !results.valid || results.ready);
    assign pixels.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        top_bit = s1_row_ge2_reg ? rd_word.upper  : border_reg;
        mid_bit = s1_row_ge1_reg ? rd_word.middle : border_reg;
        newcol  = {s1_pix_reg, mid_bit, top_bit};
        bcol    = {3{border_reg}};
        shifted = {newcol, window_reg[8:3]};
        centre  = window_reg[8:6];
        if (s1_col_zero_reg)
        begin
            left  = (ew >= EW'(2)) ? window_reg[5:3] : bcol;
            right = bcol;
        end
        else
        begin
            left  = s1_col_ge2_reg ? window_reg[5:3] : bcol;
            right = newcol;
        end
        nine        = {right, centre, left};
        res_bit     = (op_mode_reg == OP_SHRINK) ? (|nine) : (&nine);
        window_next = s1_last_reg ? '0 : shifted;
        wr_word     = '{middle: s1_pix_reg, upper: mid_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (size_write)
        begin
            window_reg <= '0;
        end
        else if (s1_adv)
        begin
            window_reg <= window_next;
        end
    end

    bmm_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (s0_col),
        .rd_data (rd_word),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (wr_word)
    );

    // output register
    logic   out_valid_reg;
    logic   out_bit_reg, out_last_reg;
    coord_t out_col_reg, out_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            out_bit_reg  <= res_bit;
            out_col_reg  <= s1_ec_reg;
            out_row_reg  <= s1_er_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.result_bit    = out_bit_reg;
    assign results.out_col       = out_col_reg;
    assign results.out_row       = out_row_reg;
    assign results.last_of_frame = out_last_reg;

`ifndef ASSERT_OFF
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s0_last && !size_write) |=> (in_col_reg == '0 && in_row_reg == '0))
        else $error("counters not cleared after frame end");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= eh_p1)
        else $error("input row beyond frame plus one");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(in_col_reg) < ew)
        else $error("input column beyond frame width");

    a_no_result_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_emit_reg) |-> pixels.ready)
        else $error("item without result stalled input");

    a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=> (window_reg == '0))
        else $error("window not cleared after frame end");
`endif

endmodule

`default_nettype wire
